// File: rtl/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared geometry, character codes, tables and types of the cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 4;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_CONSOLE_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_ATTRIBUTE = 1'b1;
    localparam logic [7:0]           ATTR_RESET         = 8'h07;

    // commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // blank light grey on black
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    // next tab stop for every column, may reach COLUMNS (wrap handled later)
    typedef logic [COL_W:0] tab_table_t [COLUMNS];

    function automatic tab_table_t build_tab_table();
        tab_table_t t;
        for (int i = 0; i < COLUMNS; i++)
        begin
            t[i] = (COL_W + 1)'(i - (i % TAB_STOP) + TAB_STOP);
        end
        return t;
    endfunction

    localparam tab_table_t TAB_NEXT = build_tab_table();

    // outcome of one put on the cursor
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              store;
        logic              scroll;
        logic [ADDR_W-1:0] addr;
    } tcce_step_t;

    // screen store access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } tcce_mem_req_t;

endpackage

// File: rtl/tcce_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_req_if
// Request channel: put character or read cell.
// ----------------------------------------------------------------------------
interface tcce_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;

    modport source (output valid, command, char_code, cell_index, input ready);
    modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

// File: rtl/tcce_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_rsp_if
// Response channel: cursor after the transaction and the cell read.
// ----------------------------------------------------------------------------
interface tcce_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor_location;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;

    modport source (output valid, cursor_location, cursor_column, cursor_row, cell_value,
                    input ready);
    modport sink   (input valid, cursor_location, cursor_column, cursor_row, cell_value,
                    output ready);
endinterface

// File: rtl/tcce_screen_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_screen_store
// Screen cell memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcce_screen_store
    import tcce_pkg::*;
(
    input  logic              clk,
    input  tcce_mem_req_t     mreq,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.re)
        begin
            rd_data <= mem[mreq.raddr];
        end
    end

endmodule

// File: rtl/tcce_cursor_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cursor_step
// Cursor movement for one character, with column wrap and scroll detect.
// ----------------------------------------------------------------------------
module tcce_cursor_step
    import tcce_pkg::*;
(
    input  logic [COL_W-1:0] col,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       char_code,
    input  logic             active,
    output tcce_step_t       step
);

    always_comb
    begin
        logic [COL_W:0] c;
        logic [ROW_W:0] r;
        logic           store;
        logic           scroll;

        c     = {1'b0, col};
        r     = {1'b0, row};
        store = 1'b0;

        if (active)
        begin
            unique case (char_code)
                CH_NL:
                begin
                    c = '0;
                    r = r + 1'b1;
                end
                CH_CR:
                begin
                    c = '0;
                end
                CH_TAB:
                begin
                    c = TAB_NEXT[col];
                end
                CH_BS:
                begin
                    if (col != '0)
                    begin
                        c = c - 1'b1;
                    end
                    else if (row != '0)
                    begin
                        c = (COL_W + 1)'(COLUMNS - 1);
                        r = r - 1'b1;
                    end
                end
                default:
                begin
                    store = 1'b1;
                    c     = c + 1'b1;
                end
            endcase
        end

        if (c >= (COL_W + 1)'(COLUMNS))
        begin
            c = '0;
            r = r + 1'b1;
        end

        scroll = (r >= (ROW_W + 1)'(ROWS));
        if (scroll)
        begin
            r = (ROW_W + 1)'(ROWS - 1);
        end

        step.col    = c[COL_W-1:0];
        step.row    = r[ROW_W-1:0];
        step.store  = store;
        step.scroll = scroll;
        step.addr   = ADDR_W'(int'(row) * COLUMNS + int'(col));
    end

endmodule

// File: rtl/text_console_cursor_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console: cursor control, screen store, scroll walk and cell read.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | command, char_code, cell_index
//  rsp     | out | valid/ready | cursor_location, cursor_column, cursor_row,
//          |     |             | cell_value
//  cfg     | in  | cfg_we      | cfg_index, cfg_data
//
//  A transaction is accepted in S_IDLE (store write or read issue, cursor
//  update); S_EMIT then loads the response from the registered store read.
//  A put that scrolls walks the store through its single read and write
//  port: S_COPY moves rows up, S_DRAIN writes the last copy, S_BLANK blanks.
//  After reset a clearing pass writes every cell with req.ready low;
//  configuration writes are taken throughout.
//  A stalled response holds the engine after one further transaction.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top
    import tcce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tcce_req_if.sink              req,
    tcce_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_BLANK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(CELLS - COLUMNS);

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              enable_reg;
    logic [7:0]        attr_reg;
    logic              rd_hit_reg;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              out_valid_reg;
    logic [10:0]       out_loc_reg;
    logic [6:0]        out_col_reg;
    logic [4:0]        out_row_reg;
    logic [15:0]       out_cell_reg;

    logic              acc;
    logic              active;
    logic              hit;
    logic              out_free;
    tcce_step_t        step;
    tcce_mem_req_t     mreq;
    logic [CELL_W-1:0] rd_data;
    logic [ADDR_W-1:0] loc;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign active    = (req.command == CMD_PUT) && enable_reg && (req.char_code != CH_NUL);
    assign hit       = (req.command == CMD_READ) && (32'(req.cell_index) < 32'(CELLS));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign loc       = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));

    tcce_cursor_step u_step
    (
        .col       (col_reg),
        .row       (row_reg),
        .char_code (req.char_code),
        .active    (active),
        .step      (step)
    );

    tcce_screen_store u_store
    (
        .clk     (clk),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    // store port selection
    always_comb
    begin
        mreq = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = ptr_reg;
                mreq.wdata = RESET_CELL;
            end
            S_IDLE:
            begin
                mreq.we    = acc && step.store;
                mreq.waddr = step.addr;
                mreq.wdata = {attr_reg, req.char_code};
                mreq.re    = acc && hit;
                mreq.raddr = ADDR_W'(req.cell_index);
            end
            S_COPY, S_DRAIN:
            begin
                mreq.we    = pend_valid_reg;
                mreq.waddr = pend_addr_reg;
                mreq.wdata = rd_data;
                mreq.re    = (state_reg == S_COPY);
                mreq.raddr = ptr_reg;
            end
            S_BLANK:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = ptr_reg;
                mreq.wdata = {attr_reg, CH_SPACE};
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    if (step.scroll)
                    begin
                        state_next = S_COPY;
                        ptr_next   = ROW_SPAN;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_COPY:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ptr_next   = LAST_ROW;
                state_next = S_BLANK;
            end
            S_BLANK:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            enable_reg     <= 1'b0;
            attr_reg       <= ATTR_RESET;
            rd_hit_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CONSOLE_ENABLE: enable_reg <= cfg_data[0];
                    REG_CELL_ATTRIBUTE: attr_reg   <= cfg_data[7:0];
                    default:            ;
                endcase
            end

            if (acc)
            begin
                col_reg    <= step.col;
                row_reg    <= step.row;
                rd_hit_reg <= hit;
            end

            // copy pipeline: read one row down, write it back one row up from the registered read data
            pend_valid_reg <= (state_reg == S_COPY);

            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= ptr_reg - ROW_SPAN;
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_loc_reg  <= 11'(loc);
            out_col_reg  <= 7'(col_reg);
            out_row_reg  <= 5'(row_reg);
            out_cell_reg <= rd_hit_reg ? rd_data : '0;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.cursor_location = out_loc_reg;
    assign rsp.cursor_column   = out_col_reg;
    assign rsp.cursor_row      = out_row_reg;
    assign rsp.cell_value      = out_cell_reg;

`ifndef NO_ASSERTIONS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)))
        else $error("cursor outside the screen");

    a_scroll_pins_row: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && step.scroll) |=> (row_reg == ROW_W'(ROWS - 1)) && (state_reg == S_COPY))
        else $error("scroll did not pin cursor to bottom row");

    a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !mreq.we)
        else $error("store written while response pending");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ((state_reg == S_COPY) || (state_reg == S_DRAIN)))
        else $error("copy write outside the scroll walk");
`endif

endmodule

// File: verif/tb_text_console_cursor_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_top
// Self-checking bench for the text console cursor engine. A local model of
// the cursor, the screen store and both registers predicts every response.
// Directed tests cover the control codes and the store edges. Random text
// lines, backspace runs, cell reads and noise then run under three idling
// profiles and several register settings.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_top;
    import tcce_pkg::*;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [10:0] location;
        logic [6:0]  column;
        logic [4:0]  row;
        logic [15:0] cell_val;
    } cursor_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcce_req_if req_bus ();
    tcce_rsp_if rsp_bus ();

    text_console_cursor_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // console model
    logic              con_enabled;
    logic [7:0]        attr_byte;
    int                cur_col;
    int                cur_row;
    logic [CELL_W-1:0] screen_image [CELLS];

    cursor_report_t expected_reports [$];
    int             mismatches;
    int             reports_shown;
    int             cycle_count;
    int             counted_items;
    int             send_idle_pct;
    int             recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // cursor and store after one transaction
    function automatic cursor_report_t advance_cursor(logic cmd, logic [7:0] ch,
                                                      logic [10:0] idx);
        cursor_report_t r;
        int             loc;
        r.cell_val = '0;
        if (cmd == CMD_PUT)
        begin
            if (con_enabled && ch != CH_NUL)
            begin
                case (ch)
                    CH_NL:
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    CH_CR:
                        cur_col = 0;
                    CH_TAB:
                        cur_col = cur_col - (cur_col % TAB_STOP) + TAB_STOP;
                    CH_BS:
                    begin
                        if (cur_col > 0)
                            cur_col--;
                        else if (cur_row > 0)
                        begin
                            cur_col = COLUMNS - 1;
                            cur_row--;
                        end
                    end
                    default:
                    begin
                        screen_image[cur_row * COLUMNS + cur_col] = {attr_byte, ch};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_image[i] = screen_image[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_image[i] = {attr_byte, CH_SPACE};
                    cur_row = ROWS - 1;
                end
            end
        end
        else if (idx < CELLS)
        begin
            r.cell_val = screen_image[idx];
        end
        loc        = cur_row * COLUMNS + cur_col;
        r.location = 11'(loc);
        r.column   = 7'(cur_col);
        r.row      = 5'(cur_row);
        return r;
    endfunction

    // one request transaction, with random idle cycles ahead of it
    task automatic send_item(logic cmd, logic [7:0] ch, logic [10:0] idx);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.command    <= cmd;
        req_bus.char_code  <= ch;
        req_bus.cell_index <= idx;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        if (cmd == CMD_READ || (con_enabled && ch != CH_NUL))
            counted_items++;
        expected_reports.push_back(advance_cursor(cmd, ch, idx));
    endtask

    task automatic put_char_item(logic [7:0] ch);
        send_item(CMD_PUT, ch, 11'($urandom));
    endtask

    task automatic read_cell_item(logic [10:0] idx);
        send_item(CMD_READ, 8'($urandom), idx);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_CONSOLE_ENABLE)
            con_enabled = data[0];
        else
            attr_byte = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // enable register: only bit 0 counts, the rest is random
    task automatic set_console(logic on);
        write_reg(REG_CONSOLE_ENABLE, {7'($urandom), on});
    endtask

    always @(negedge clk)
        rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : rsp_check
        cursor_report_t got;
        cursor_report_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = {rsp_bus.cursor_location, rsp_bus.cursor_column,
                   rsp_bus.cursor_row, rsp_bus.cell_value};
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (reports_shown < MAX_REPORTS)
                begin
                    reports_shown++;
                    $display("unexpected response: loc %0d col %0d row %0d cell %h",
                             got.location, got.column, got.row, got.cell_val);
                end
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.location !== want.location || got.column !== want.column ||
                    got.row !== want.row || got.cell_val !== want.cell_val)
                begin
                    mismatches++;
                    if (reports_shown < MAX_REPORTS)
                    begin
                        reports_shown++;
                        $display("mismatch: exp loc %0d col %0d row %0d cell %h",
                                 want.location, want.column, want.row, want.cell_val);
                        $display("          got loc %0d col %0d row %0d cell %h",
                                 got.location, got.column, got.row, got.cell_val);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------ tests

    task automatic test_disabled_console();
        put_char_item(8'h41);
        put_char_item(CH_NL);
        read_cell_item(11'd0);
        read_cell_item(11'd2047);
    endtask

    task automatic test_control_codes();
        set_console(1'b1);
        write_reg(REG_CELL_ATTRIBUTE, 8'hFF);
        put_char_item(CH_BS);          // stays at the origin
        put_char_item(8'hFF);
        put_char_item(8'h80);
        put_char_item(CH_NUL);         // terminator, nothing printed
        put_char_item(CH_TAB);
        put_char_item(CH_CR);
        put_char_item(CH_TAB);
        put_char_item(CH_NL);
        put_char_item(CH_BS);          // back to the end of row 0
        put_char_item(CH_TAB);         // tab past the last column wraps
        put_char_item(CH_BS);
        put_char_item(8'h7E);          // print on the last column wraps
        read_cell_item(11'd0);
        read_cell_item(11'd79);
        read_cell_item(11'd1999);
        read_cell_item(11'd2000);
    endtask

    task automatic test_bottom_row_scroll();
        write_reg(REG_CELL_ATTRIBUTE, 8'h00);
        while (cur_row < ROWS - 1)
            put_char_item(CH_NL);
        put_char_item(8'h55);
        put_char_item(CH_NL);          // scroll by newline
        for (int k = 0; k < COLUMNS; k++)
            put_char_item(8'($urandom_range(8'h21, 8'h7E)));  // last one wraps and scrolls
        read_cell_item(11'(CELLS - 2 * COLUMNS));
        read_cell_item(11'(CELLS - COLUMNS));
        read_cell_item(11'(CELLS - 1));
    endtask

    task automatic send_text_line();
        int len;
        int pick;
        len = $urandom_range(0, 90);
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                put_char_item(CH_TAB);
            else if (pick < 8)
                put_char_item(CH_BS);
            else if (pick < 14)
                put_char_item(8'($urandom_range(8'h80, 8'hFF)));
            else
                put_char_item(8'($urandom_range(8'h20, 8'h7E)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            put_char_item(CH_CR);
            put_char_item(CH_NL);
        end
        else if (pick < 85)
        begin
            put_char_item(CH_NL);
        end
    endtask

    task automatic test_random_text(int n_items, int s_idle, int r_idle);
        int start;
        int kind;
        int count;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        start = counted_items;
        while (counted_items - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                send_text_line();
            end
            else if (kind < 78)
            begin
                count = $urandom_range(1, 6);
                for (int k = 0; k < count; k++)
                begin
                    if ($urandom_range(0, 1))
                        read_cell_item(11'($urandom_range(0, 2047)));
                    else
                        read_cell_item(11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
                end
            end
            else if (kind < 88)
            begin
                count = $urandom_range(1, 100);
                for (int k = 0; k < count; k++)
                    put_char_item(CH_BS);
            end
            else
            begin
                count = $urandom_range(1, 8);
                for (int k = 0; k < count; k++)
                    send_item($urandom_range(0, 1) ? CMD_READ : CMD_PUT, 8'($urandom),
                              11'($urandom));
            end
        end
    endtask

    task automatic test_disable_midstream();
        set_console(1'b0);
        for (int k = 0; k < 20; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                read_cell_item(11'($urandom_range(0, 2047)));
            else
                put_char_item(8'($urandom));
        end
        set_console(1'b1);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_bus.valid      = 1'b0;
        req_bus.command    = CMD_PUT;
        req_bus.char_code  = '0;
        req_bus.cell_index = '0;
        rsp_bus.ready      = 1'b0;
        cycle_count        = 0;
        mismatches         = 0;
        reports_shown      = 0;
        counted_items      = 0;
        send_idle_pct      = 15;
        recv_idle_pct      = 88;
        con_enabled        = 1'b0;
        attr_byte          = ATTR_RESET;
        cur_col            = 0;
        cur_row            = 0;
        for (int i = 0; i < CELLS; i++)
            screen_image[i] = RESET_CELL;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_disabled_console();
        test_control_codes();
        test_bottom_row_scroll();
        test_random_text(300, 15, 88);
        write_reg(REG_CELL_ATTRIBUTE, 8'($urandom));
        test_random_text(300, 88, 15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_disable_midstream();
        write_reg(REG_CELL_ATTRIBUTE, 8'hFF);
        test_random_text(300, 0, 0);

        wait_quiet();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: text_console_cursor_engine_top.f
rtl/tcce_pkg.sv
rtl/tcce_req_if.sv
rtl/tcce_rsp_if.sv
rtl/tcce_screen_store.sv
rtl/tcce_cursor_step.sv
rtl/text_console_cursor_engine_top.sv
verif/tb_text_console_cursor_engine_top.sv
